### src/v3a_pkg.sv
// Shared op codes and control types for the vector3 fixed-point ALU.
package v3a_pkg;

  // Operation codes carried in the input tuser field
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_DOT   = 4'd4;
  localparam logic [3:0] OP_CROSS = 4'd5;
  localparam logic [3:0] OP_MAG   = 4'd6;
  localparam logic [3:0] OP_NORM  = 4'd7;
  localparam logic [3:0] OP_DIST  = 4'd8;

  // Control bits that ride along the pipeline with each item
  typedef struct packed {
    logic [3:0] op;
    logic       sat;   // some component already clipped
    logic       big;   // distance difference out of range
  } v3a_ctrl_t;

endpackage

### src/v3a_front.sv
// Front stages: add/sub, products, floor shift and sum of squares.
module v3a_front #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [3:0]            in_op,
  input  logic signed [W-1:0]   in_a [3],
  input  logic signed [W-1:0]   in_b [3],
  output logic                  out_valid,
  output v3a_pkg::v3a_ctrl_t    out_ctrl,
  output logic signed [W-1:0]   out_r [3],
  output logic [2*W-1:0]        out_rad,
  output logic signed [W-1:0]   out_a [3],
  output logic signed [W-1:0]   out_b [3]
);

  localparam int XW = 2*W + 2;
  localparam logic signed [XW-1:0] XMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] XMIN = ~XMAX;

  function automatic logic ovf(input logic signed [XW-1:0] v);
    return (v > XMAX) || (v < XMIN);
  endfunction

  function automatic logic signed [W-1:0] clip(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = v;
    if (v > XMAX) t = XMAX;
    if (v < XMIN) t = XMIN;
    return t[W-1:0];
  endfunction

  function automatic logic [W-1:0] absw(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = (v < 0) ? -v : v;
    return t[W-1:0];
  endfunction

  // ---------------- stage 1: add/sub, distance differences
  logic signed [XW-1:0] sum_x [3];
  logic signed [XW-1:0] dif_x [3];
  logic signed [XW-1:0] dba_x [3];
  logic signed [W-1:0]  r1 [3];
  logic [W-1:0]         m1 [3];
  logic                 sat1, big1;

  logic                 s1_v;
  v3a_pkg::v3a_ctrl_t   s1_ctrl;
  logic signed [W-1:0]  s1_r [3];
  logic [W-1:0]         s1_m [3];
  logic signed [W-1:0]  s1_a [3];
  logic signed [W-1:0]  s1_b [3];

  always_comb begin
    sat1 = 1'b0;
    big1 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum_x[i] = XW'(in_a[i]) + XW'(in_b[i]);
      dif_x[i] = XW'(in_a[i]) - XW'(in_b[i]);
      dba_x[i] = XW'(in_b[i]) - XW'(in_a[i]);
      r1[i] = '0;
      // the most negative difference has no positive twin: counts as too big
      if ((dba_x[i] > XMAX) || (dba_x[i] <= XMIN)) big1 = 1'b1;
      m1[i] = (in_op == v3a_pkg::OP_DIST) ? absw(dba_x[i]) : absw(XW'(in_a[i]));
      case (in_op)
        v3a_pkg::OP_ADD: begin
          r1[i] = clip(sum_x[i]);
          if (ovf(sum_x[i])) sat1 = 1'b1;
        end
        v3a_pkg::OP_SUB: begin
          r1[i] = clip(dif_x[i]);
          if (ovf(dif_x[i])) sat1 = 1'b1;
        end
        default: r1[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
    if (en) begin
      s1_ctrl <= '{op: in_op, sat: sat1, big: big1};
      s1_r    <= r1;
      s1_m    <= m1;
      s1_a    <= in_a;
      s1_b    <= in_b;
    end
  end

  // ---------------- stage 2: multipliers
  logic                  s2_v;
  v3a_pkg::v3a_ctrl_t    s2_ctrl;
  logic signed [W-1:0]   s2_r [3];
  logic signed [2*W-1:0] s2_p [3];
  logic signed [2*W-1:0] s2_c [6];
  logic [2*W-1:0]        s2_sq [3];
  logic signed [W-1:0]   s2_a [3];
  logic signed [W-1:0]   s2_b [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2_ctrl <= s1_ctrl;
      s2_r    <= s1_r;
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      for (int i = 0; i < 3; i++) begin
        s2_p[i]  <= s1_a[i] * s1_b[i];
        s2_sq[i] <= s1_m[i] * s1_m[i];
      end
      // cross terms: x = ay*bz - az*by, y = az*bx - ax*bz, z = ax*by - ay*bx
      s2_c[0] <= s1_a[1] * s1_b[2];
      s2_c[1] <= s1_a[2] * s1_b[1];
      s2_c[2] <= s1_a[2] * s1_b[0];
      s2_c[3] <= s1_a[0] * s1_b[2];
      s2_c[4] <= s1_a[0] * s1_b[1];
      s2_c[5] <= s1_a[1] * s1_b[0];
    end
  end

  // ---------------- stage 3: floor shift, sums, clipping
  logic signed [XW-1:0] pf [3];
  logic signed [XW-1:0] cd [3];
  logic signed [XW-1:0] dot_x;
  logic signed [W-1:0]  r3 [3];
  logic                 sat3;
  logic [2*W-1:0]       rad3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pf[i] = XW'(s2_p[i]) >>> F;
      cd[i] = (XW'(s2_c[2*i]) - XW'(s2_c[2*i+1])) >>> F;
    end
    dot_x = pf[0] + pf[1] + pf[2];
    rad3  = s2_sq[0] + s2_sq[1] + s2_sq[2];
    sat3  = s2_ctrl.sat;
    for (int i = 0; i < 3; i++) r3[i] = '0;
    unique case (s2_ctrl.op) inside
      v3a_pkg::OP_ADD, v3a_pkg::OP_SUB: begin
        r3 = s2_r;
      end
      v3a_pkg::OP_MUL: begin
        for (int i = 0; i < 3; i++) begin
          r3[i] = clip(pf[i]);
          if (ovf(pf[i])) sat3 = 1'b1;
        end
      end
      v3a_pkg::OP_DOT: begin
        r3[0] = clip(dot_x);
        if (ovf(dot_x)) sat3 = 1'b1;
      end
      v3a_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          r3[i] = clip(cd[i]);
          if (ovf(cd[i])) sat3 = 1'b1;
        end
      end
      default: sat3 = s2_ctrl.sat;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_v;
    end
    if (en) begin
      out_ctrl <= '{op: s2_ctrl.op, sat: sat3, big: s2_ctrl.big};
      out_r    <= r3;
      out_rad  <= rad3;
      out_a    <= s2_a;
      out_b    <= s2_b;
    end
  end

endmodule

### src/v3a_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module v3a_sqrt #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*W-1:0]  in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [W-1:0]    out_root,
  output logic [SW-1:0]   out_side
);

  logic           v    [1:W];
  logic [2*W-1:0] rad  [1:W];
  logic [W+1:0]   rem  [1:W];
  logic [W-1:0]   root [1:W];
  logic [SW-1:0]  side [1:W];

  for (genvar k = 0; k < W; k++) begin : g_st
    logic           cv;
    logic [2*W-1:0] crad;
    logic [W+1:0]   crem;
    logic [W-1:0]   croot;
    logic [SW-1:0]  cside;
    logic [W+2:0]   tr, tt, td;
    logic           ge;

    if (k == 0) begin : g_in
      assign cv    = in_valid;
      assign crad  = in_rad;
      assign crem  = '0;
      assign croot = '0;
      assign cside = in_side;
    end else begin : g_mid
      assign cv    = v[k];
      assign crad  = rad[k];
      assign crem  = rem[k];
      assign croot = root[k];
      assign cside = side[k];
    end

    // trial subtract of (4*root + 1) from the shifted remainder
    assign tr = {crem[W:0], crad[2*W-1 -: 2]};
    assign tt = {1'b0, croot, 2'b01};
    assign ge = (tr >= tt);
    assign td = tr - tt;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= cv;
      end
      if (en) begin
        rem[k+1]  <= ge ? td[W+1:0] : tr[W+1:0];
        root[k+1] <= {croot[W-2:0], ge};
        rad[k+1]  <= {crad[2*W-3:0], 2'b00};
        side[k+1] <= cside;
      end
    end
  end

  assign out_valid = v[W];
  assign out_root  = root[W];
  assign out_side  = side[W];

endmodule

### src/v3a_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module v3a_div #(
  parameter int NW = 48,
  parameter int W  = 32,
  parameter int SW = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  in_num,
  input  logic [W-1:0]   in_den,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [NW-1:0]  out_quo,
  output logic [SW-1:0]  out_side
);

  logic          v    [1:NW];
  logic [NW-1:0] nq   [1:NW];
  logic [W-1:0]  rem  [1:NW];
  logic [W-1:0]  den  [1:NW];
  logic [SW-1:0] side [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic          cv;
    logic [NW-1:0] cnq;
    logic [W-1:0]  crem;
    logic [W-1:0]  cden;
    logic [SW-1:0] cside;
    logic [W:0]    tr, td;
    logic          ge;

    if (k == 0) begin : g_in
      assign cv    = in_valid;
      assign cnq   = in_num;
      assign crem  = '0;
      assign cden  = in_den;
      assign cside = in_side;
    end else begin : g_mid
      assign cv    = v[k];
      assign cnq   = nq[k];
      assign crem  = rem[k];
      assign cden  = den[k];
      assign cside = side[k];
    end

    // shift in the next dividend bit, subtract when it fits
    assign tr = {crem, cnq[NW-1]};
    assign ge = (tr >= {1'b0, cden});
    assign td = tr - {1'b0, cden};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= cv;
      end
      if (en) begin
        rem[k+1]  <= ge ? td[W-1:0] : tr[W-1:0];
        nq[k+1]   <= {cnq[NW-2:0], ge};
        den[k+1]  <= cden;
        side[k+1] <= cside;
      end
    end
  end

  assign out_valid = v[NW];
  assign out_quo   = nq[NW];
  assign out_side  = side[NW];

endmodule

### src/vector3_fixed_point_alu.sv
// Top level of the vector3 fixed-point ALU: front, root, dividers, output stage.
//
//  channel | dir | signals                          | contents
//  s       | in  | s_tvalid s_tready s_tdata s_tuser | op code, vectors a and b
//  m       | out | m_tvalid m_tready m_tdata m_tuser | result vector and flags
//
// One item per cycle while m is not stalled. Depth grows with WORD_BITS and
// FRAC_BITS (Q16.16 by default), set by the bit-per-stage root and dividers.
// Every op takes the same path, so results leave in input order.
// rst is synchronous and clears only the valid bits.
// A stall on m freezes the whole pipeline; s_tready falls in the same cycle.
module vector3_fixed_point_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // ax, ay, az, bx, by, bz from the lowest bit up, zero padded
  input  logic [((6*WORD_BITS+7)/8)*8-1:0]      s_tdata,
  // op
  input  logic [3:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // rx, ry, rz from the lowest bit up, zero padded
  output logic [((3*WORD_BITS+7)/8)*8-1:0]      m_tdata,
  // div_by_zero, saturated
  output logic [1:0]                            m_tuser
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NW  = W + F;
  localparam int CW  = $bits(v3a_pkg::v3a_ctrl_t);
  localparam int QSW = CW + 9*W;
  localparam int D0W = CW + 3*W + 2;
  localparam int MDW = ((3*W+7)/8)*8;
  localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [NW-1:0] QMAX = {{(F+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NW-1:0] QMIN = QMAX + 1'b1;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // input unpack
  logic signed [W-1:0] in_a [3];
  logic signed [W-1:0] in_b [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_a[i] = s_tdata[i*W +: W];
      in_b[i] = s_tdata[(i+3)*W +: W];
    end
  end

  // ---------------- front stages
  logic                 fr_v;
  v3a_pkg::v3a_ctrl_t   fr_ctrl;
  logic signed [W-1:0]  fr_r [3];
  logic [2*W-1:0]       fr_rad;
  logic signed [W-1:0]  fr_a [3];
  logic signed [W-1:0]  fr_b [3];

  v3a_front #(.W(W), .F(F)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_tvalid),
    .in_op     (s_tuser),
    .in_a      (in_a),
    .in_b      (in_b),
    .out_valid (fr_v),
    .out_ctrl  (fr_ctrl),
    .out_r     (fr_r),
    .out_rad   (fr_rad),
    .out_a     (fr_a),
    .out_b     (fr_b)
  );

  // ---------------- square root
  logic [QSW-1:0]       fr_side, sq_side;
  logic                 sq_v;
  logic [W-1:0]         sq_root;
  v3a_pkg::v3a_ctrl_t   sq_ctrl;
  logic signed [W-1:0]  sq_r [3];
  logic signed [W-1:0]  sq_a [3];
  logic signed [W-1:0]  sq_b [3];

  assign fr_side = {fr_ctrl, fr_r[0], fr_r[1], fr_r[2],
                    fr_a[0], fr_a[1], fr_a[2], fr_b[0], fr_b[1], fr_b[2]};

  v3a_sqrt #(.W(W), .SW(QSW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (fr_v),
    .in_rad    (fr_rad),
    .in_side   (fr_side),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign {sq_ctrl, sq_r[0], sq_r[1], sq_r[2],
          sq_a[0], sq_a[1], sq_a[2], sq_b[0], sq_b[1], sq_b[2]} = sq_side;

  // ---------------- divider operand stage
  logic                 is_div;
  logic [W-1:0]         abs_a [3];
  logic [W-1:0]         abs_b [3];
  logic [W-1:0]         den_c [3];
  logic                 neg_c [3];
  logic signed [W-1:0]  r_c [3];
  logic                 sat_c;

  logic                 pv;
  v3a_pkg::v3a_ctrl_t   pctrl;
  logic signed [W-1:0]  pr [3];
  logic                 pneg [3];
  logic                 pdz [3];
  logic [NW-1:0]        pnum [3];
  logic [W-1:0]         pden [3];

  always_comb begin
    is_div = (sq_ctrl.op == v3a_pkg::OP_DIV);
    for (int i = 0; i < 3; i++) begin
      abs_a[i] = sq_a[i][W-1] ? (~sq_a[i] + 1'b1) : sq_a[i];
      abs_b[i] = sq_b[i][W-1] ? (~sq_b[i] + 1'b1) : sq_b[i];
      den_c[i] = is_div ? abs_b[i] : sq_root;
      neg_c[i] = sq_a[i][W-1] ^ (is_div & sq_b[i][W-1]);
    end
    r_c   = sq_r;
    sat_c = sq_ctrl.sat;
    // scalar root results land in x
    unique case (sq_ctrl.op)
      v3a_pkg::OP_MAG: begin
        if (sq_root > WMAX) begin
          r_c[0] = WMAX;
          sat_c  = 1'b1;
        end else begin
          r_c[0] = sq_root;
        end
      end
      v3a_pkg::OP_DIST: begin
        if (sq_ctrl.big || (sq_root > WMAX)) begin
          r_c[0] = WMAX;
          sat_c  = 1'b1;
        end else begin
          r_c[0] = sq_root;
        end
      end
      default: sat_c = sq_ctrl.sat;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (adv) begin
      pv <= sq_v;
    end
    if (adv) begin
      pctrl <= '{op: sq_ctrl.op, sat: sat_c, big: sq_ctrl.big};
      pr    <= r_c;
      for (int i = 0; i < 3; i++) begin
        pneg[i] <= neg_c[i];
        pdz[i]  <= (den_c[i] == '0);
        pnum[i] <= {abs_a[i], {F{1'b0}}};
        pden[i] <= den_c[i];
      end
    end
  end

  // ---------------- divider lanes
  logic [D0W-1:0]       d0_in, d0_out;
  logic [1:0]           d1_out, d2_out;
  logic                 dv [3];
  logic [NW-1:0]        dq [3];
  v3a_pkg::v3a_ctrl_t   dctrl;
  logic signed [W-1:0]  dr [3];
  logic                 dneg [3];
  logic                 ddz [3];

  assign d0_in = {pctrl, pr[0], pr[1], pr[2], pneg[0], pdz[0]};

  v3a_div #(.NW(NW), .W(W), .SW(D0W)) u_div0 (
    .clk (clk), .rst (rst), .en (adv), .in_valid (pv),
    .in_num (pnum[0]), .in_den (pden[0]), .in_side (d0_in),
    .out_valid (dv[0]), .out_quo (dq[0]), .out_side (d0_out)
  );

  v3a_div #(.NW(NW), .W(W), .SW(2)) u_div1 (
    .clk (clk), .rst (rst), .en (adv), .in_valid (pv),
    .in_num (pnum[1]), .in_den (pden[1]), .in_side ({pneg[1], pdz[1]}),
    .out_valid (dv[1]), .out_quo (dq[1]), .out_side (d1_out)
  );

  v3a_div #(.NW(NW), .W(W), .SW(2)) u_div2 (
    .clk (clk), .rst (rst), .en (adv), .in_valid (pv),
    .in_num (pnum[2]), .in_den (pden[2]), .in_side ({pneg[2], pdz[2]}),
    .out_valid (dv[2]), .out_quo (dq[2]), .out_side (d2_out)
  );

  assign {dctrl, dr[0], dr[1], dr[2], dneg[0], ddz[0]} = d0_out;
  assign {dneg[1], ddz[1]} = d1_out;
  assign {dneg[2], ddz[2]} = d2_out;

  // ---------------- sign, clip and select, then output register
  logic                 use_q;
  logic signed [W-1:0]  fin [3];
  logic                 fin_dz, fin_sat;
  logic signed [W-1:0]  rx, ry, rz;
  logic                 div_by_zero, saturated;

  always_comb begin
    use_q   = (dctrl.op == v3a_pkg::OP_DIV) || (dctrl.op == v3a_pkg::OP_NORM);
    fin_dz  = 1'b0;
    fin_sat = dctrl.sat;
    fin     = dr;
    if (use_q) begin
      for (int i = 0; i < 3; i++) begin
        if (ddz[i]) begin
          fin[i] = '0;
          fin_dz = 1'b1;
        end else if (!dneg[i]) begin
          if (dq[i] > QMAX) begin
            fin[i]  = WMAX;
            fin_sat = 1'b1;
          end else begin
            fin[i] = dq[i][W-1:0];
          end
        end else begin
          if (dq[i] > QMIN) begin
            fin[i]  = ~WMAX;
            fin_sat = 1'b1;
          end else begin
            fin[i] = ~dq[i][W-1:0] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv[0] & dv[1] & dv[2];
    end
    if (adv) begin
      rx          <= fin[0];
      ry          <= fin[1];
      rz          <= fin[2];
      div_by_zero <= fin_dz;
      saturated   <= fin_sat;
    end
  end

  assign m_tdata = MDW'({rz, ry, rx});
  assign m_tuser = {saturated, div_by_zero};

endmodule

### src/v3a_checker.sv
// Port-level checker for the vector3 fixed-point ALU, with its bind.
module v3a_checker #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [((6*WORD_BITS+7)/8)*8-1:0]   s_tdata,
  input logic [3:0]                         s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [((3*WORD_BITS+7)/8)*8-1:0]   m_tdata,
  input logic [1:0]                         m_tuser
);

  localparam int FILL = FRAC_BITS;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input is open exactly when the output can move
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output backpressure");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // m_tvalid stays low after reset, though the check does not span the whole pipeline
  a_no_early: assert property (@(posedge clk)
    (rst && (FILL >= 0)) |=> ##1 !m_tvalid)
    else $error("result appeared too soon after reset");

  logic unused_in;
  assign unused_in = s_tvalid ^ (^s_tdata) ^ (^s_tuser);

endmodule

bind vector3_fixed_point_alu v3a_checker #(
  .WORD_BITS(WORD_BITS),
  .FRAC_BITS(FRAC_BITS)
) u_v3a_checker (.*);
